FILE: design/rclfr_pkg.sv
// ----------------------------------------------------------------------------
// rclfr_pkg
// Shared types, constants and the crc-8 step for the rc link frame receiver.
// ----------------------------------------------------------------------------
package rclfr_pkg;

  // framing constants
  localparam logic [7:0]  SYNC_BYTE    = 8'hC8;
  localparam logic [7:0]  CRC_POLY     = 8'hD5;
  localparam logic [7:0]  CHAN_TYPE    = 8'h16;
  localparam int          CHAN_PAYLOAD = 22;
  localparam int          CHAN_LEN     = CHAN_PAYLOAD + 2;
  localparam int          CHAN_COUNT   = 16;
  localparam int          CHAN_BITS    = 11;
  localparam int          TIMEOUT_W    = 24;
  localparam logic [23:0] TIMEOUT_RESET = 24'd200000;

  // defaults for the top level parameters
  localparam int MAX_FRAME_LEN_DEF       = 64;
  localparam int SILENCE_COUNT_WIDTH_DEF = 24;

  // payload store geometry
  localparam int PAYLOAD_AW = $clog2(CHAN_PAYLOAD);

  // item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_GOOD = 3'd1,
    EV_CRC  = 3'd2,
    EV_LEN  = 3'd3,
    EV_CHAN = 3'd4,
    EV_LOST = 3'd5
  } event_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    event_t      event_res;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        link_up;
    logic        last;
  } out_item_t;

  // status from the channel unpacker to the top level
  typedef struct packed {
    logic        busy;
    logic        chan_valid;
    logic [3:0]  chan_index;
    logic [10:0] chan_value;
  } unp_stat_t;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: design/rc_link_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// rc_link_frame_receiver_unit
// Byte-wise frame parser with running crc-8 and link-loss supervision; the
// channel payload is kept in a small ram and unpacked into channels from it.
// ----------------------------------------------------------------------------
// Each parser result is registered into the output register on the transfer of its item.
// Throughput: one item per cycle, byte or tick, with the output taken each cycle and no channel frame unpacking.
// Channel frame: 16 results after the crc byte, paced by the ram read port and the
//   24-bit unpack accumulator; no input is taken until the last channel has been given.
// Reset (rst_n, synchronous): parser to sync hunt, link down, silence zero,
//   timeout 200000; the payload ram is not cleared.
module rc_link_frame_receiver_unit #(
  parameter int MAX_FRAME_LEN       = rclfr_pkg::MAX_FRAME_LEN_DEF,
  parameter int SILENCE_COUNT_WIDTH = rclfr_pkg::SILENCE_COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rclfr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rclfr_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [rclfr_pkg::TIMEOUT_W-1:0] cfg_wdata
);

  localparam int SW    = SILENCE_COUNT_WIDTH;
  localparam int CMP_W = (SW > rclfr_pkg::TIMEOUT_W) ? SW : rclfr_pkg::TIMEOUT_W;

  rclfr_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]         frame_size_r, frame_size_nxt;
  logic [7:0]         byte_cnt_r, byte_cnt_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [7:0]         frame_type_r, frame_type_nxt;
  logic               link_r, link_nxt;
  logic [SW-1:0]      silence_r, silence_nxt;
  logic [rclfr_pkg::TIMEOUT_W-1:0] timeout_r;
  logic               out_valid_r, out_valid_nxt;
  rclfr_pkg::out_item_t out_r, out_nxt;

  logic                 accept;
  logic                 slot_free;
  rclfr_pkg::event_t    ev;
  logic                 unp_start;
  logic [7:0]           crc_new;
  logic [8:0]           cnt_inc;
  logic [SW-1:0]        sil_inc;
  logic                 ram_we;
  logic [rclfr_pkg::PAYLOAD_AW-1:0] ram_waddr;
  logic                 ram_re;
  logic [rclfr_pkg::PAYLOAD_AW-1:0] ram_raddr;
  logic [7:0]           ram_rdata;
  rclfr_pkg::unp_stat_t unp_stat;

  // handshake: the output register frees on transfer, unpacking blocks input
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = slot_free && !unp_stat.busy;
  assign accept    = in_valid && in_ready;

  assign crc_new = rclfr_pkg::crc8_step(crc_r, in_data.rx_byte);
  assign cnt_inc = {1'b0, byte_cnt_r} + 9'd1;
  assign sil_inc = (silence_r != {SW{1'b1}}) ? (silence_r + 1'b1) : silence_r;

  // parser, crc and link supervision
  always_comb begin
    phase_nxt      = phase_r;
    frame_size_nxt = frame_size_r;
    byte_cnt_nxt   = byte_cnt_r;
    crc_nxt        = crc_r;
    frame_type_nxt = frame_type_r;
    link_nxt       = link_r;
    silence_nxt    = silence_r;
    ev             = rclfr_pkg::EV_NONE;
    unp_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = rclfr_pkg::PAYLOAD_AW'(byte_cnt_r - 8'd1);

    if (accept) begin
      if (in_data.opcode == rclfr_pkg::OP_TICK) begin
        silence_nxt = sil_inc;
        if (link_r && (CMP_W'(sil_inc) > CMP_W'(timeout_r))) begin
          link_nxt = 1'b0;
          ev       = rclfr_pkg::EV_LOST;
        end
      end else begin
        case (phase_r)
          rclfr_pkg::PH_LEN: begin
            if ((in_data.rx_byte < 8'd2) || (in_data.rx_byte > 8'(MAX_FRAME_LEN))) begin
              ev        = rclfr_pkg::EV_LEN;
              phase_nxt = rclfr_pkg::PH_SYNC;
            end else begin
              frame_size_nxt = in_data.rx_byte;
              byte_cnt_nxt   = 8'd0;
              crc_nxt        = 8'd0;
              phase_nxt      = rclfr_pkg::PH_TYPE;
            end
          end
          rclfr_pkg::PH_TYPE: begin
            frame_type_nxt = in_data.rx_byte;
            crc_nxt        = crc_new;
            byte_cnt_nxt   = 8'd1;
            // a type-only frame has its crc next
            phase_nxt = (frame_size_r == 8'd2) ? rclfr_pkg::PH_CRC : rclfr_pkg::PH_PAYLOAD;
          end
          rclfr_pkg::PH_PAYLOAD: begin
            // only the first 22 payload bytes are stored
            ram_we       = (byte_cnt_r != 8'd0) &&
                           (byte_cnt_r <= 8'(rclfr_pkg::CHAN_PAYLOAD));
            crc_nxt      = crc_new;
            byte_cnt_nxt = cnt_inc[7:0];
            if ((cnt_inc + 9'd1) >= {1'b0, frame_size_r}) begin
              phase_nxt = rclfr_pkg::PH_CRC;
            end
          end
          rclfr_pkg::PH_CRC: begin
            phase_nxt = rclfr_pkg::PH_SYNC;
            if (in_data.rx_byte != crc_r) begin
              ev = rclfr_pkg::EV_CRC;
            end else if ((frame_type_r == rclfr_pkg::CHAN_TYPE) &&
                         (frame_size_r == 8'(rclfr_pkg::CHAN_LEN))) begin
              link_nxt    = 1'b1;
              silence_nxt = '0;
              unp_start   = 1'b1;
            end else begin
              ev = rclfr_pkg::EV_GOOD;
            end
          end
          default: begin
            phase_nxt = (in_data.rx_byte == rclfr_pkg::SYNC_BYTE) ?
                        rclfr_pkg::PH_LEN : rclfr_pkg::PH_SYNC;
          end
        endcase
      end
    end
  end

  // output register: single results from the parser, channels from the unpacker
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (accept && !unp_start) begin
      out_valid_nxt         = 1'b1;
      out_nxt.event_res     = ev;
      out_nxt.channel_index = '0;
      out_nxt.channel_value = '0;
      out_nxt.link_up       = link_nxt;
      out_nxt.last          = 1'b1;
    end else if (unp_stat.chan_valid && slot_free) begin
      out_valid_nxt         = 1'b1;
      out_nxt.event_res     = rclfr_pkg::EV_CHAN;
      out_nxt.channel_index = unp_stat.chan_index;
      out_nxt.channel_value = unp_stat.chan_value;
      out_nxt.link_up       = link_r;
      out_nxt.last          = (unp_stat.chan_index == 4'(rclfr_pkg::CHAN_COUNT - 1));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rclfr_pkg::PH_SYNC;
      frame_size_r <= '0;
      byte_cnt_r   <= '0;
      crc_r        <= '0;
      frame_type_r <= '0;
      link_r       <= 1'b0;
      silence_r    <= '0;
      timeout_r    <= rclfr_pkg::TIMEOUT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      frame_size_r <= frame_size_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      crc_r        <= crc_nxt;
      frame_type_r <= frame_type_nxt;
      link_r       <= link_nxt;
      silence_r    <= silence_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // payload store
  rclfr_ram #(
    .WIDTH (8),
    .DEPTH (rclfr_pkg::CHAN_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // channel unpacker
  rclfr_chan_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (unp_start),
    .chan_ready (slot_free),
    .rd_en      (ram_re),
    .rd_addr    (ram_raddr),
    .rd_data    (ram_rdata),
    .stat       (unp_stat)
  );

`ifndef SYNTHESIS
  a_no_input_while_unpacking: assert property (@(posedge clk) disable iff (!rst_n)
    unp_stat.busy |-> !in_ready)
    else $error("input taken while channels are still being unpacked");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    unp_start |=> unp_stat.busy)
    else $error("channel frame did not start the unpacker");

  a_chan_link_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.event_res == rclfr_pkg::EV_CHAN)) |-> (link_r && out_r.link_up))
    else $error("channel result with link down");

  a_lost_clears_link: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ev == rclfr_pkg::EV_LOST)) |=> !link_r && (silence_r != '0))
    else $error("link loss did not clear the link flag");
`endif

endmodule

FILE: design/rclfr_ram.sv
// ----------------------------------------------------------------------------
// rclfr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rclfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rclfr_chan_unpack.sv
// ----------------------------------------------------------------------------
// rclfr_chan_unpack
// Reads the 22 stored payload bytes, at most one per cycle, and slices them
// into sixteen 11-bit channels, lsb first, through a bit accumulator.
// ----------------------------------------------------------------------------
module rclfr_chan_unpack (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           chan_ready,
  output logic                           rd_en,
  output logic [rclfr_pkg::PAYLOAD_AW-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  output rclfr_pkg::unp_stat_t           stat
);

  localparam int ACC_W = 24;

  logic                            busy_r, busy_nxt;
  logic                            pend_r, pend_nxt;
  logic [rclfr_pkg::PAYLOAD_AW:0]  addr_r, addr_nxt;
  logic [ACC_W-1:0]                acc_r, acc_nxt;
  logic [4:0]                      cnt_r, cnt_nxt;
  logic [3:0]                      idx_r, idx_nxt;

  logic             chan_valid;
  logic             take;
  logic [ACC_W-1:0] acc_a;
  logic [4:0]       cnt_a;
  logic [ACC_W-1:0] acc_b;
  logic [4:0]       cnt_b;
  logic             more;

  // a channel is ready once eleven bits sit in the accumulator
  assign chan_valid = busy_r && (cnt_r >= 5'(rclfr_pkg::CHAN_BITS));
  assign take       = chan_valid && chan_ready;
  assign more       = addr_r < (rclfr_pkg::PAYLOAD_AW + 1)'(rclfr_pkg::CHAN_PAYLOAD);

  always_comb begin
    // consume a channel
    acc_a = take ? (acc_r >> rclfr_pkg::CHAN_BITS) : acc_r;
    cnt_a = take ? (cnt_r - 5'(rclfr_pkg::CHAN_BITS)) : cnt_r;
    // append the byte coming back from the ram
    acc_b = acc_a;
    cnt_b = cnt_a;
    if (pend_r) begin
      acc_b = acc_a | ({{(ACC_W-8){1'b0}}, rd_data} << cnt_a);
      cnt_b = cnt_a + 5'd8;
    end
    // read ahead only while the next byte is sure to fit
    rd_en = busy_r && more && ((6'(cnt_b) + 6'd8) <= 6'(ACC_W));

    busy_nxt = busy_r;
    pend_nxt = rd_en;
    addr_nxt = rd_en ? (addr_r + 1'b1) : addr_r;
    acc_nxt  = acc_b;
    cnt_nxt  = cnt_b;
    idx_nxt  = take ? (idx_r + 1'b1) : idx_r;
    if (take && (idx_r == 4'(rclfr_pkg::CHAN_COUNT - 1))) begin
      busy_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      addr_nxt = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      idx_nxt  = '0;
    end
  end

  assign rd_addr = addr_r[rclfr_pkg::PAYLOAD_AW-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      addr_r <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      addr_r <= addr_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // status towards the top level
  always_comb begin
    stat.busy       = busy_r;
    stat.chan_valid = chan_valid;
    stat.chan_index = idx_r;
    stat.chan_value = acc_r[rclfr_pkg::CHAN_BITS-1:0];
  end

`ifndef SYNTHESIS
  a_acc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(ACC_W))
    else $error("bit accumulator overfilled");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> more)
    else $error("payload read past the stored bytes");

  a_last_chan_all_read: assert property (@(posedge clk) disable iff (!rst_n)
    (chan_valid && (idx_r == 4'(rclfr_pkg::CHAN_COUNT - 1))) |->
      (addr_r == (rclfr_pkg::PAYLOAD_AW + 1)'(rclfr_pkg::CHAN_PAYLOAD)) && !pend_r)
    else $error("last channel given before all payload bytes arrived");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !rd_en && !chan_valid)
    else $error("unpacker active while idle");
`endif

endmodule
